/* hdl/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the point rotate/offset/crop unit
// item structs, configuration register indexes and coordinate saturation
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int PRC_FRAC_BITS  = 12;     // default fraction bits of coordinates
    localparam int PRC_ROT_BITS   = 14;     // fraction bits of cosine/sine
    localparam int PRC_COORD_W    = 24;
    localparam int PRC_TRIG_W     = 16;
    localparam int PRC_CFG_IDX_W  = 3;
    localparam int PRC_CFG_DATA_W = 24;
    localparam int PRC_WIDE_W     = 42;     // rotation sum plus rounding headroom

    localparam logic [PRC_CFG_IDX_W-1:0] CFG_FRONT_COS = 3'd0;
    localparam logic [PRC_CFG_IDX_W-1:0] CFG_FRONT_SIN = 3'd1;
    localparam logic [PRC_CFG_IDX_W-1:0] CFG_REAR_COS  = 3'd2;
    localparam logic [PRC_CFG_IDX_W-1:0] CFG_REAR_SIN  = 3'd3;
    localparam logic [PRC_CFG_IDX_W-1:0] CFG_SHIFT_X   = 3'd4;
    localparam logic [PRC_CFG_IDX_W-1:0] CFG_SHIFT_Y   = 3'd5;

    localparam logic OP_FRONT = 1'b0;
    localparam logic OP_REAR  = 1'b1;

    localparam logic signed [PRC_WIDE_W-1:0] COORD_MAX = 42'sd8388607;
    localparam logic signed [PRC_WIDE_W-1:0] COORD_MIN = -42'sd8388608;

    typedef struct packed {
        logic                          operation;
        logic signed [PRC_COORD_W-1:0] point_x;
        logic signed [PRC_COORD_W-1:0] point_y;
    } t_prc_in;

    typedef struct packed {
        logic                          keep;
        logic signed [PRC_COORD_W-1:0] out_x;
        logic signed [PRC_COORD_W-1:0] out_y;
    } t_prc_out;

    typedef struct packed {
        logic signed [PRC_TRIG_W-1:0]  front_cos;
        logic signed [PRC_TRIG_W-1:0]  front_sin;
        logic signed [PRC_TRIG_W-1:0]  rear_cos;
        logic signed [PRC_TRIG_W-1:0]  rear_sin;
        logic signed [PRC_COORD_W-1:0] shift_x;
        logic signed [PRC_COORD_W-1:0] shift_y;
    } t_prc_cfg;

    // rotated point handed from the rotation pipe to the offset/crop pipe
    typedef struct packed {
        logic                          valid;
        logic                          rear;
        logic signed [PRC_COORD_W-1:0] x;
        logic signed [PRC_COORD_W-1:0] y;
    } t_prc_rot;

    function automatic logic signed [PRC_COORD_W-1:0] sat_coord(
        input logic signed [PRC_WIDE_W-1:0] v
    );
        logic signed [PRC_WIDE_W-1:0] c;
        begin
            if (v > COORD_MAX) begin
                c = COORD_MAX;
            end else if (v < COORD_MIN) begin
                c = COORD_MIN;
            end else begin
                c = v;
            end
            sat_coord = c[PRC_COORD_W-1:0];
        end
    endfunction

endpackage

/* hdl/point_rotate_offset_crop_unit.sv */
// ----------------------------------------------------------------------------
// point_rotate_offset_crop_unit: 2d rigid transform and crop of sensor points
// rotates a front or rear sensor point, adds mount and odometry offsets and
// drops points in the self box or outside the crop box
// ----------------------------------------------------------------------------
// usage:
//   input channel: drive i_item and pulse start; an item is taken at each
//   clock edge where start is high and busy is low. busy is always low, so
//   one item can enter every cycle.
//   result channel: o_result is shown for one cycle with o_strobe high, once
//   the item has passed the pipeline below (throughput 1/cycle).
//   there is no backpressure: the receiver must take each result when shown.
//   pipeline: capture, multiply (four 24x16 products in parallel), round and
//   saturate, rear pre-drop and mount offset, self box and odometry, crop
//   box and output register. the multiplier stage sets the clock limit.
//   configuration: i_cfg_we/i_cfg_idx/i_cfg_data write one register per
//   cycle; write only while no item is in flight.
//   reset (i_rst_n low, synchronous): clears the valid bits of all stages and
//   loads unit cosines and zero sines and shifts.
// ----------------------------------------------------------------------------
module point_rotate_offset_crop_unit
    import prc_pkg::*;
#(
    parameter int FRAC_BITS = PRC_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // item input
    input  logic                      start,
    output logic                      busy,
    input  t_prc_in                   i_item,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [PRC_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [PRC_CFG_DATA_W-1:0] i_cfg_data,
    // result output
    output logic                      o_strobe,
    output t_prc_out                  o_result
);

    t_prc_cfg cfg;      // current register values
    t_prc_rot rot;      // rotated point between the two pipes
    logic     accept;

    // the pipe never stalls, so the block is never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;

    prc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // stages a to c: capture, products, rounded rotation
    prc_rotate u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .i_cfg   (cfg),
        .o_rot   (rot)
    );

    // stages d to f: offsets, box tests, output register
    prc_offset_crop #(
        .FRAC_BITS (FRAC_BITS)
    ) u_crop (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rot    (rot),
        .i_cfg    (cfg),
        .o_valid  (o_strobe),
        .o_result (o_result)
    );

endmodule

/* hdl/prc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// prc_cfg_regs: configuration register file
// rotation cosines/sines per sensor and odometry shift, write only
// ----------------------------------------------------------------------------
module prc_cfg_regs
    import prc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [PRC_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [PRC_CFG_DATA_W-1:0] i_cfg_data,
    output t_prc_cfg                  o_cfg
);

    t_prc_cfg r_cfg;
    t_prc_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRONT_COS: n_cfg.front_cos = i_cfg_data[PRC_TRIG_W-1:0];
                CFG_FRONT_SIN: n_cfg.front_sin = i_cfg_data[PRC_TRIG_W-1:0];
                CFG_REAR_COS:  n_cfg.rear_cos  = i_cfg_data[PRC_TRIG_W-1:0];
                CFG_REAR_SIN:  n_cfg.rear_sin  = i_cfg_data[PRC_TRIG_W-1:0];
                CFG_SHIFT_X:   n_cfg.shift_x   = i_cfg_data[PRC_COORD_W-1:0];
                CFG_SHIFT_Y:   n_cfg.shift_y   = i_cfg_data[PRC_COORD_W-1:0];
                default:       n_cfg = r_cfg;   // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.front_cos <= 16'sd16384;
            r_cfg.front_sin <= '0;
            r_cfg.rear_cos  <= 16'sd16384;
            r_cfg.rear_sin  <= '0;
            r_cfg.shift_x   <= '0;
            r_cfg.shift_y   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/prc_rotate.sv */
// ----------------------------------------------------------------------------
// prc_rotate: three-stage rotation pipe
// input capture, four parallel products, sum with rounding and saturation
// ----------------------------------------------------------------------------
module prc_rotate
    import prc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_prc_in  i_item,
    input  t_prc_cfg i_cfg,
    output t_prc_rot o_rot
);

    localparam int PROD_W = PRC_COORD_W + PRC_TRIG_W;

    // stage a: captured point and selected angle
    logic                          r_a_valid;
    logic                          r_a_rear;
    logic signed [PRC_COORD_W-1:0] r_a_x;
    logic signed [PRC_COORD_W-1:0] r_a_y;
    logic signed [PRC_TRIG_W-1:0]  r_a_cos;
    logic signed [PRC_TRIG_W-1:0]  r_a_sin;

    // stage b: products
    logic                     r_b_valid;
    logic                     r_b_rear;
    logic signed [PROD_W-1:0] r_b_xc;
    logic signed [PROD_W-1:0] r_b_ys;
    logic signed [PROD_W-1:0] r_b_xs;
    logic signed [PROD_W-1:0] r_b_yc;

    // stage c: rotated point
    t_prc_rot r_c;

    logic signed [PROD_W-1:0]     n_b_xc, n_b_ys, n_b_xs, n_b_yc;
    logic signed [PRC_WIDE_W-1:0] xr_sum, yr_sum;
    logic signed [PRC_WIDE_W-1:0] xr_shf, yr_shf;
    localparam logic signed [PRC_WIDE_W-1:0] ROUND_HALF =
        PRC_WIDE_W'(longint'(1) << (PRC_ROT_BITS - 1));

    always_comb begin
        n_b_xc = PROD_W'(r_a_x) * PROD_W'(r_a_cos);
        n_b_ys = PROD_W'(r_a_y) * PROD_W'(r_a_sin);
        n_b_xs = PROD_W'(r_a_x) * PROD_W'(r_a_sin);
        n_b_yc = PROD_W'(r_a_y) * PROD_W'(r_a_cos);
    end

    always_comb begin
        xr_sum = PRC_WIDE_W'(r_b_xc) - PRC_WIDE_W'(r_b_ys) + ROUND_HALF;
        yr_sum = PRC_WIDE_W'(r_b_xs) + PRC_WIDE_W'(r_b_yc) + ROUND_HALF;
        xr_shf = xr_sum >>> PRC_ROT_BITS;
        yr_shf = yr_sum >>> PRC_ROT_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c.valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c.valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_rear <= (i_item.operation == OP_REAR);
        r_a_x    <= i_item.point_x;
        r_a_y    <= i_item.point_y;
        r_a_cos  <= (i_item.operation == OP_REAR) ? i_cfg.rear_cos : i_cfg.front_cos;
        r_a_sin  <= (i_item.operation == OP_REAR) ? i_cfg.rear_sin : i_cfg.front_sin;

        r_b_rear <= r_a_rear;
        r_b_xc   <= n_b_xc;
        r_b_ys   <= n_b_ys;
        r_b_xs   <= n_b_xs;
        r_b_yc   <= n_b_yc;

        r_c.rear <= r_b_rear;
        r_c.x    <= sat_coord(xr_shf);
        r_c.y    <= sat_coord(yr_shf);
    end

    assign o_rot = r_c;

endmodule

/* hdl/prc_offset_crop.sv */
// ----------------------------------------------------------------------------
// prc_offset_crop: three-stage filter pipe
// rear pre-drop and mount offset, self box and odometry, crop box and output
// ----------------------------------------------------------------------------
module prc_offset_crop
    import prc_pkg::*;
#(
    parameter int FRAC_BITS = PRC_FRAC_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_prc_rot i_rot,
    input  t_prc_cfg i_cfg,
    output logic     o_valid,
    output t_prc_out o_result
);

    localparam longint SCALE = longint'(1) << FRAC_BITS;
    // decimal constants rounded to nearest, halves away from zero
    localparam logic signed [PRC_COORD_W-1:0] SELF_H =
        PRC_COORD_W'((longint'(305500) * SCALE + 500000) / 1000000);
    localparam logic signed [PRC_COORD_W-1:0] SELF_W =
        PRC_COORD_W'((longint'(315500) * SCALE + 500000) / 1000000);
    localparam logic signed [PRC_COORD_W-1:0] CROP_Y_HI =
        PRC_COORD_W'((longint'(3684500) * SCALE + 500000) / 1000000);
    localparam logic signed [PRC_COORD_W-1:0] CROP_X_HI =
        PRC_COORD_W'((longint'(14694500) * SCALE + 500000) / 1000000);
    localparam logic signed [PRC_COORD_W-1:0] HALF_LEN =
        PRC_COORD_W'((longint'(257525) * SCALE + 500000) / 1000000);
    localparam logic signed [PRC_COORD_W-1:0] REAR_X_LIM =
        PRC_COORD_W'(-((longint'(300000) * SCALE + 500000) / 1000000));
    localparam logic signed [PRC_COORD_W-1:0] REAR_Y_LIM =
        PRC_COORD_W'((longint'(200000) * SCALE + 500000) / 1000000);
    localparam logic signed [PRC_COORD_W-1:0] CROP_Y_LO = -SELF_W;
    localparam logic signed [PRC_COORD_W-1:0] CROP_X_LO = -SELF_H;

    // stage d: after mount offset
    logic                          r_d_valid, r_d_rear, r_d_keep;
    logic signed [PRC_COORD_W-1:0] r_d_x, r_d_y;
    // stage e: after odometry shift
    logic                          r_e_valid, r_e_keep;
    logic signed [PRC_COORD_W-1:0] r_e_x, r_e_y;
    // stage f: output
    logic     r_f_valid;
    t_prc_out r_f;

    logic                          n_d_keep;
    logic signed [PRC_COORD_W-1:0] n_d_x, n_d_y;
    logic signed [PRC_COORD_W:0]   off_x, off_y;
    logic                          self_hit;
    logic signed [PRC_COORD_W:0]   sft_x, sft_y;
    logic                          crop_hit;
    logic                          n_f_keep;

    always_comb begin
        n_d_keep = !(i_rot.rear && (i_rot.x >= REAR_X_LIM) && (i_rot.y <= REAR_Y_LIM));
        if (i_rot.rear) begin
            off_x = (PRC_COORD_W+1)'(i_rot.x) - (PRC_COORD_W+1)'(HALF_LEN);
            off_y = (PRC_COORD_W+1)'(i_rot.y) + (PRC_COORD_W+1)'(HALF_LEN);
        end else begin
            off_x = (PRC_COORD_W+1)'(i_rot.x) + (PRC_COORD_W+1)'(HALF_LEN);
            off_y = (PRC_COORD_W+1)'(i_rot.y) - (PRC_COORD_W+1)'(HALF_LEN);
        end
        n_d_x = sat_coord(PRC_WIDE_W'(off_x));
        n_d_y = sat_coord(PRC_WIDE_W'(off_y));
    end

    always_comb begin
        // rear tests x alone, front tests |x|
        self_hit = (r_d_x <= SELF_H) && (r_d_rear || (r_d_x >= -SELF_H))
                   && (r_d_y <= SELF_W) && (r_d_y >= -SELF_W);
        sft_x = (PRC_COORD_W+1)'(r_d_x) + (PRC_COORD_W+1)'(i_cfg.shift_x);
        sft_y = (PRC_COORD_W+1)'(r_d_y) + (PRC_COORD_W+1)'(i_cfg.shift_y);
    end

    always_comb begin
        crop_hit = (r_e_x <= CROP_X_LO) || (r_e_x >= CROP_X_HI)
                   || (r_e_y <= CROP_Y_LO) || (r_e_y >= CROP_Y_HI);
        n_f_keep = r_e_keep && !crop_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            r_d_valid <= i_rot.valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_rear <= i_rot.rear;
        r_d_keep <= n_d_keep;
        r_d_x    <= n_d_x;
        r_d_y    <= n_d_y;

        r_e_keep <= r_d_keep && !self_hit;
        r_e_x    <= sat_coord(PRC_WIDE_W'(sft_x));
        r_e_y    <= sat_coord(PRC_WIDE_W'(sft_y));

        r_f.keep  <= n_f_keep;
        r_f.out_x <= n_f_keep ? r_e_x : '0;
        r_f.out_y <= n_f_keep ? r_e_y : '0;
    end

    assign o_valid  = r_f_valid;
    assign o_result = r_f;

endmodule

/* hdl/prc_checker.sv */
// ----------------------------------------------------------------------------
// prc_port_checks: port-level checks of the point rotate/offset/crop unit
// never busy, fixed latency, one result per item, zeroed coordinates on drop
// ----------------------------------------------------------------------------
module prc_port_checks
    import prc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_strobe,
    input t_prc_out o_result
);

    a_never_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a non-stalling pipe");

    a_item_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("accepted item produced no result after six cycles");

    a_result_has_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 6))
        else $error("result strobe without an accepted item");

    a_drop_zeroes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.keep) |-> (o_result.out_x == '0 && o_result.out_y == '0))
        else $error("dropped point carries nonzero coordinates");

endmodule

bind point_rotate_offset_crop_unit prc_port_checks u_prc_port_checks (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

/* tb/sv/prc_checker.sv */
// ----------------------------------------------------------------------------
// prc_checker: result predictor and scoreboard for point_rotate_offset_crop_unit
// follows register writes and accepted points, predicts the world point and
// keep flag of each one and compares every strobed result in order
// ----------------------------------------------------------------------------
module prc_checker
    import prc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  t_prc_in                   i_item,
    input  logic                      i_cfg_we,
    input  logic [PRC_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [PRC_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                      i_strobe,
    input  t_prc_out                  i_result,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // decimal meters given in micrometers, rounded to the nearest fixed point step
    function automatic longint to_fixed(input longint micro);
        return (micro * (longint'(1) << PRC_FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    endfunction

    localparam longint SELF_X    = to_fixed(305500);
    localparam longint SELF_Y    = to_fixed(315500);
    localparam longint CROP_X_HI = to_fixed(14694500);
    localparam longint CROP_Y_HI = to_fixed(3684500);
    localparam longint MOUNT     = to_fixed(257525);
    localparam longint PRE_X     = to_fixed(300000);
    localparam longint PRE_Y     = to_fixed(200000);
    localparam longint COORD_HI  = 64'sd8388607;
    localparam longint COORD_LO  = -64'sd8388608;

    logic signed [PRC_TRIG_W-1:0]  cos_f, sin_f, cos_r, sin_r;
    logic signed [PRC_COORD_W-1:0] odo_x, odo_y;
    t_prc_out                      due_results[$];
    t_prc_out                      want;
    int                            fail_n = 0;
    int                            pend_n = 0;

    assign o_fail_count = fail_n;
    assign o_pending    = pend_n;

    function automatic longint clamp24(input longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // round half up at the q1.14 point, then saturate
    function automatic longint scale_rot(input longint v);
        return clamp24((v + (longint'(1) << (PRC_ROT_BITS - 1))) >>> PRC_ROT_BITS);
    endfunction

    function automatic t_prc_out world_point(input t_prc_in pt);
        longint   cs, sn, px, py, x, y;
        logic     rear, keep;
        t_prc_out res;
        rear = (pt.operation == OP_REAR);
        cs   = rear ? longint'(cos_r) : longint'(cos_f);
        sn   = rear ? longint'(sin_r) : longint'(sin_f);
        px   = longint'(pt.point_x);
        py   = longint'(pt.point_y);
        x    = scale_rot(px * cs - py * sn);
        y    = scale_rot(px * sn + py * cs);
        keep = 1'b1;
        if (rear) begin
            if (x >= -PRE_X && y <= PRE_Y) keep = 1'b0;
            x = clamp24(x - MOUNT);
            y = clamp24(y + MOUNT);
            if (x <= SELF_X && magnitude(y) <= SELF_Y) keep = 1'b0;
        end else begin
            x = clamp24(x + MOUNT);
            y = clamp24(y - MOUNT);
            if (magnitude(x) <= SELF_X && magnitude(y) <= SELF_Y) keep = 1'b0;
        end
        x = clamp24(x + longint'(odo_x));
        y = clamp24(y + longint'(odo_y));
        if (x <= -SELF_X || x >= CROP_X_HI || y <= -SELF_Y || y >= CROP_Y_HI) keep = 1'b0;
        res.keep  = keep;
        res.out_x = keep ? x[PRC_COORD_W-1:0] : '0;
        res.out_y = keep ? y[PRC_COORD_W-1:0] : '0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cos_f = 16'sd16384;
            sin_f = '0;
            cos_r = 16'sd16384;
            sin_r = '0;
            odo_x = '0;
            odo_y = '0;
            due_results.delete();
        end else begin
            // a strobed result always belongs to an earlier point, so compare before queuing
            if (i_strobe) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with no point pending: expected none actual keep=%0b x=%0d y=%0d",
                             $time, i_result.keep, i_result.out_x, i_result.out_y);
                    fail_n++;
                end else begin
                    want = due_results.pop_front();
                    if (i_result.keep !== want.keep) begin
                        $display("%0t: keep mismatch: expected %0b actual %0b",
                                 $time, want.keep, i_result.keep);
                        fail_n++;
                    end
                    if (i_result.out_x !== want.out_x) begin
                        $display("%0t: out_x mismatch: expected %0d actual %0d",
                                 $time, want.out_x, i_result.out_x);
                        fail_n++;
                    end
                    if (i_result.out_y !== want.out_y) begin
                        $display("%0t: out_y mismatch: expected %0d actual %0d",
                                 $time, want.out_y, i_result.out_y);
                        fail_n++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRONT_COS: cos_f = i_cfg_data[PRC_TRIG_W-1:0];
                    CFG_FRONT_SIN: sin_f = i_cfg_data[PRC_TRIG_W-1:0];
                    CFG_REAR_COS:  cos_r = i_cfg_data[PRC_TRIG_W-1:0];
                    CFG_REAR_SIN:  sin_r = i_cfg_data[PRC_TRIG_W-1:0];
                    CFG_SHIFT_X:   odo_x = i_cfg_data[PRC_COORD_W-1:0];
                    CFG_SHIFT_Y:   odo_y = i_cfg_data[PRC_COORD_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) due_results = {due_results, world_point(i_item)};
        end
        pend_n = due_results.size();
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: regression of point_rotate_offset_crop_unit
// drives directed edge points and long random runs of aimed and raw points
// through a series of rotation and shift settings; prc_checker predicts and
// compares every result, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module testbench;
    import prc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     UNIT           = 1 << PRC_FRAC_BITS;  // one meter
    localparam longint AIM_MOUNT      = 1055;    // mount offset used to aim points
    localparam int     SETTLE         = 8;       // pipeline latency plus margin
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PHASES         = 12;
    localparam int     PHASE_ITEMS    = 127;
    localparam int     COORD_MAX_I    = 8388607;
    localparam int     COORD_MIN_I    = -8388608;

    // register indexes the block does not decode
    localparam logic [PRC_CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [PRC_CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    t_prc_in                   item;
    logic                      cfg_we;
    logic [PRC_CFG_IDX_W-1:0]  cfg_idx;
    logic [PRC_CFG_DATA_W-1:0] cfg_data;
    logic                      strobe;
    t_prc_out                  result;
    int                        fail_count;
    int                        pending;
    int                        stall_cycles = 0;

    // settings as last loaded, used only to aim points into the crop box
    logic signed [PRC_TRIG_W-1:0]  aim_fc, aim_fs, aim_rc, aim_rs;
    logic signed [PRC_COORD_W-1:0] aim_sx, aim_sy;

    point_rotate_offset_crop_unit #(
        .FRAC_BITS (PRC_FRAC_BITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_strobe   (strobe),
        .o_result   (result)
    );

    prc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_strobe     (strobe),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hang detector: cycles with no point, result or register write taken
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("point_rotate_offset_crop_unit regression: fail");
            $finish;
        end
    end

    // present one item at a falling edge and hold it until taken; returns at a
    // falling edge with start still high so back-to-back items stay dense
    task automatic send_point(input t_prc_in pt);
        start <= 1'b1;
        item  <= pt;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // quiet the input until every predicted result has come out
    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [PRC_CFG_IDX_W-1:0] idx,
                             input logic [PRC_CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // trig registers get random junk above bit 15, the block must ignore it
    task automatic load_config(input int fc, input int fs, input int rc, input int rs,
                               input int sx, input int sy);
        aim_fc = fc[15:0];
        aim_fs = fs[15:0];
        aim_rc = rc[15:0];
        aim_rs = rs[15:0];
        aim_sx = sx[23:0];
        aim_sy = sy[23:0];
        write_reg(CFG_FRONT_COS, {8'($urandom_range(0, 255)), fc[15:0]});
        write_reg(CFG_FRONT_SIN, {8'($urandom_range(0, 255)), fs[15:0]});
        write_reg(CFG_REAR_COS,  {8'($urandom_range(0, 255)), rc[15:0]});
        write_reg(CFG_REAR_SIN,  {8'($urandom_range(0, 255)), rs[15:0]});
        write_reg(CFG_SHIFT_X,   sx[23:0]);
        write_reg(CFG_SHIFT_Y,   sy[23:0]);
        // writes to undecoded indexes must leave everything alone
        write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, 24'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic t_prc_in local_point(input logic op, input int x, input int y);
        t_prc_in p;
        p.operation = op;
        p.point_x   = x[23:0];
        p.point_y   = y[23:0];
        return p;
    endfunction

    function automatic logic signed [PRC_COORD_W-1:0] clip_coord(input longint v);
        logic signed [PRC_WIDE_W-1:0] w;
        w = PRC_WIDE_W'(v);
        return sat_coord(w);
    endfunction

    // back out mount offset, shift and rotation so the point lands near (tx, ty)
    function automatic t_prc_in aim_point(input logic op, input longint tx, input longint ty);
        longint  c, s, dx, dy;
        t_prc_in p;
        c = (op == OP_REAR) ? longint'(aim_rc) : longint'(aim_fc);
        s = (op == OP_REAR) ? longint'(aim_rs) : longint'(aim_fs);
        if (op == OP_REAR) begin
            dx = tx - aim_sx + AIM_MOUNT;
            dy = ty - aim_sy - AIM_MOUNT;
        end else begin
            dx = tx - aim_sx - AIM_MOUNT;
            dy = ty - aim_sy + AIM_MOUNT;
        end
        p.operation = op;
        p.point_x   = clip_coord((dx * c + dy * s) >>> PRC_ROT_BITS);
        p.point_y   = clip_coord((dy * c - dx * s) >>> PRC_ROT_BITS);
        return p;
    endfunction

    function automatic logic signed [PRC_COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 3))
            0:       return 24'sh7fffff;
            1:       return 24'sh800000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic t_prc_in random_point();
        int      pick;
        logic    op;
        longint  tx, ty;
        t_prc_in p;
        pick = $urandom_range(0, 99);
        op   = 1'($urandom_range(0, 1));
        if (pick < 70) begin
            // mostly aimed around the crop box and its edges
            tx = longint'($urandom_range(0, 17 * UNIT)) - 2 * UNIT;
            ty = longint'($urandom_range(0, 7 * UNIT)) - 2 * UNIT;
            p  = aim_point(op, tx, ty);
        end else if (pick < 85) begin
            tx = longint'($urandom_range(0, 40 * UNIT)) - 20 * UNIT;
            ty = longint'($urandom_range(0, 40 * UNIT)) - 20 * UNIT;
            p  = local_point(op, int'(tx), int'(ty));
        end else if (pick < 95) begin
            p = $bits(t_prc_in)'({$urandom, $urandom});
        end else begin
            p.operation = op;
            p.point_x   = corner_coord();
            p.point_y   = corner_coord();
        end
        return p;
    endfunction

    function automatic int rand_trig();
        if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic int rand_shift();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 16777215)) - 8388608;
        return int'($urandom_range(0, 10 * UNIT)) - 5 * UNIT;
    endfunction

    initial begin : stimulus
        bit idle_on;
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_FRONT_COS;
        cfg_data = '0;
        aim_fc   = 16'sd16384;
        aim_fs   = '0;
        aim_rc   = 16'sd16384;
        aim_rs   = '0;
        aim_sx   = '0;
        aim_sy   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: identity rotation, no shift
        send_point(local_point(OP_FRONT, 0, 0));                      // own box
        send_point(local_point(OP_FRONT, COORD_MAX_I, COORD_MAX_I));  // saturates
        send_point(local_point(OP_FRONT, COORD_MIN_I, COORD_MIN_I));
        send_point(local_point(OP_FRONT, 5 * UNIT, UNIT));            // kept
        // crop box edges, one step inside and on the edge
        send_point(local_point(OP_FRONT, 59133, UNIT));
        send_point(local_point(OP_FRONT, 59134, UNIT));
        send_point(local_point(OP_FRONT, UNIT, 16146));
        send_point(local_point(OP_FRONT, UNIT, 16147));
        send_point(local_point(OP_FRONT, -2305, UNIT));
        send_point(local_point(OP_FRONT, -2306, UNIT));
        send_point(local_point(OP_FRONT, 20000, -236));
        send_point(local_point(OP_FRONT, 20000, -237));
        // rear: early drop region, its edges, kept point and own box
        send_point(local_point(OP_REAR, 0, 0));
        send_point(local_point(OP_REAR, -1229, 819));
        send_point(local_point(OP_REAR, 20000, 819));
        send_point(local_point(OP_REAR, 20000, 820));
        send_point(local_point(OP_REAR, 5 * UNIT, 2 * UNIT));
        send_point(local_point(OP_REAR, -2000, 0));
        send_point(local_point(OP_REAR, COORD_MIN_I, COORD_MAX_I));
        send_point(local_point(OP_REAR, COORD_MAX_I, COORD_MIN_I));
        pause_sender(3);
        send_point(local_point(OP_FRONT, -1, -1));

        // registers at the ends of the q1.14 range and shifts at the limits
        wait_idle();
        load_config(32767, -32768, -32768, 32767, COORD_MAX_I, COORD_MIN_I);
        send_point(local_point(OP_FRONT, UNIT, UNIT));
        send_point(local_point(OP_REAR, -UNIT, UNIT));
        send_point(local_point(OP_FRONT, COORD_MAX_I, COORD_MIN_I));

        for (int k = 0; k < PHASES; k++) begin
            // the sender drains fully before every register change
            wait_idle();
            case (k)
                0: load_config(16384, 0, -16384, 0, 0, 0);
                1: load_config(0, 16384, 0, -16384, 2 * UNIT, -UNIT);
                2: load_config(11585, 11585, -11585, 11585, rand_shift(), rand_shift());
                3: load_config(16384, -16384, -16384, 16384, COORD_MAX_I, COORD_MIN_I);
                4: load_config(-16384, 0, 16384, 0, COORD_MIN_I, COORD_MAX_I);
                default: load_config(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                                     rand_shift(), rand_shift());
            endcase
            // no gaps at all in the last phase
            idle_on = (k != PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_point(random_point());
                // gaps come in bursts, with quiet stretches in between
                if (idle_on && ((i / 32) % 2 == 0) && $urandom_range(0, 5) == 0)
                    pause_sender($urandom_range(1, 10));
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("point_rotate_offset_crop_unit regression: pass");
        end else begin
            $display("point_rotate_offset_crop_unit regression: fail");
        end
        $finish;
    end

endmodule
